/* src/srtl_pkg.sv */
// shared types and constants for the sorted range table lookup block
// no dependencies
package srtl_pkg;

    localparam int DEF_ENTRIES = 64;
    localparam int ADDR_W      = 64;
    localparam int INDEX_W     = 6;
    localparam int STATUS_W    = 3;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_LOOKUP = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_NOTREADY = 3'd2,
        ST_FULL     = 3'd3,
        ST_SKIPPED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_SORT_OUTER,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_LK_PROBE,
        S_LK_RD,
        S_LK_CMP,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    do_clear;
        logic    do_insert;
        logic    set_ready;
        logic    sort_init;
        logic    sort_load_key;
        logic    sort_rd;
        logic    sort_shift;
        logic    sort_put;
        logic    sort_next;
        logic    lk_init;
        logic    lk_rd;
        logic    lk_step;
        logic    emit;
        status_t emit_status;
        logic    emit_data;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic ready;
        logic sort_more;
        logic sort_can_move;
        logic sort_need_shift;
        logic lk_more;
        logic lk_hit;
    } stat_t;

endpackage

/* src/sorted_range_table_lookup_top.sv */
// top level of the sorted range table lookup block
// depends on srtl_pkg, srtl_ctrl, srtl_dp
//
// channel  | signals                                             | handshake
// command  | func start_addr end_addr file_offset is_special    | start & !busy
//          | query_addr                                          |
// result   | status region_index region_offset region_start     | strobe, one cycle
//          | region_end                                          |
//
// clear, skipped or full insert and not-ready lookup: result in the cycle after transfer
// insert: via S_INS and S_DONE; lookup: S_LK_PROBE, S_LK_RD, S_LK_CMP per probe, up to log2(ENTRIES)+1 probes
// finish: insertion sort through the region memory, which has one read and one write port
// reset empties the table; the result side cannot stall
module sorted_range_table_lookup_top
    import srtl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [ADDR_W-1:0]   start_addr,
    input  logic [ADDR_W-1:0]   end_addr,
    input  logic [ADDR_W-1:0]   file_offset,
    input  logic                is_special,
    input  logic [ADDR_W-1:0]   query_addr,
    output logic                strobe,
    output logic [STATUS_W-1:0] status,
    output logic [INDEX_W-1:0]  region_index,
    output logic [ADDR_W-1:0]   region_offset,
    output logic [ADDR_W-1:0]   region_start,
    output logic [ADDR_W-1:0]   region_end
);

    ctrl_t ctl;
    stat_t st;

    srtl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .is_special (is_special),
        .st         (st),
        .ctl        (ctl),
        .busy       (busy)
    );

    srtl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .start_addr    (start_addr),
        .end_addr      (end_addr),
        .file_offset   (file_offset),
        .query_addr    (query_addr),
        .st            (st),
        .strobe        (strobe),
        .status        (status),
        .region_index  (region_index),
        .region_offset (region_offset),
        .region_start  (region_start),
        .region_end    (region_end)
    );

endmodule

/* src/srtl_ctrl.sv */
// controller state machine for the sorted range table lookup block
// depends on srtl_pkg
module srtl_ctrl
    import srtl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  func,
    input  logic        is_special,
    input  stat_t       st,
    output ctrl_t       ctl,
    output logic        busy
);

    state_t state_reg, state_next;
    func_t  func_in;

    assign func_in = func_t'(func);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func_in)
                        FUNC_CLEAR:  state_next = S_IDLE;
                        FUNC_INSERT: state_next = S_INS;
                        FUNC_FINISH: state_next = S_SORT_OUTER;
                        FUNC_LOOKUP: state_next = st.ready ? S_LK_PROBE : S_IDLE;
                        default:     state_next = S_IDLE;
                    endcase
                    if (func_in == FUNC_INSERT && (is_special || st.full))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_INS:        state_next = S_DONE;
            S_SORT_OUTER: state_next = st.sort_more ? S_SORT_CMP : S_IDLE;
            S_SORT_CMP:   state_next = st.sort_can_move ? S_SORT_RD : S_SORT_PUT;
            S_SORT_RD:    state_next = st.sort_need_shift ? S_SORT_CMP : S_SORT_PUT;
            S_SORT_PUT:   state_next = S_SORT_OUTER;
            S_LK_PROBE:   state_next = st.lk_more ? S_LK_RD : S_IDLE;
            S_LK_RD:      state_next = S_LK_CMP;
            S_LK_CMP:     state_next = st.lk_hit ? S_DONE : S_LK_PROBE;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.emit_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch_in = 1'b1;
                    case (func_in)
                        FUNC_CLEAR:
                        begin
                            ctl.do_clear = 1'b1;
                            ctl.emit = 1'b1;
                        end
                        FUNC_INSERT:
                        begin
                            if (is_special)
                            begin
                                ctl.emit = 1'b1;
                                ctl.emit_status = ST_SKIPPED;
                            end
                            else if (st.full)
                            begin
                                ctl.emit = 1'b1;
                                ctl.emit_status = ST_FULL;
                            end
                        end
                        FUNC_FINISH: ctl.sort_init = 1'b1;
                        FUNC_LOOKUP:
                        begin
                            if (st.ready)
                            begin
                                ctl.lk_init = 1'b1;
                            end
                            else
                            begin
                                ctl.emit = 1'b1;
                                ctl.emit_status = ST_NOTREADY;
                            end
                        end
                        default: ctl.latch_in = 1'b1;
                    endcase
                end
            end
            S_INS: ctl.do_insert = 1'b1;
            S_SORT_OUTER:
            begin
                if (st.sort_more)
                begin
                    ctl.sort_load_key = 1'b1;
                end
                else
                begin
                    ctl.set_ready = 1'b1;
                    ctl.emit = 1'b1;
                end
            end
            S_SORT_CMP:
            begin
                if (st.sort_can_move)
                begin
                    ctl.sort_rd = 1'b1;
                end
            end
            S_SORT_RD:
            begin
                if (st.sort_need_shift)
                begin
                    ctl.sort_shift = 1'b1;
                end
            end
            S_SORT_PUT:
            begin
                ctl.sort_put = 1'b1;
                ctl.sort_next = 1'b1;
            end
            S_LK_PROBE:
            begin
                if (!st.lk_more)
                begin
                    ctl.emit = 1'b1;
                    ctl.emit_status = ST_NOTFOUND;
                end
            end
            S_LK_RD: ctl.lk_rd = 1'b1;
            S_LK_CMP: ctl.lk_step = 1'b1;
            S_DONE:
            begin
                ctl.emit = 1'b1;
                ctl.emit_data = 1'b1;
            end
            default: ctl.latch_in = 1'b0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* src/srtl_dp.sv */
// datapath for the sorted range table lookup block: region memory, sort and search
// depends on srtl_pkg
module srtl_dp
    import srtl_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctl,
    input  logic [ADDR_W-1:0]   start_addr,
    input  logic [ADDR_W-1:0]   end_addr,
    input  logic [ADDR_W-1:0]   file_offset,
    input  logic [ADDR_W-1:0]   query_addr,
    output stat_t               st,
    output logic                strobe,
    output logic [STATUS_W-1:0] status,
    output logic [INDEX_W-1:0]  region_index,
    output logic [ADDR_W-1:0]   region_offset,
    output logic [ADDR_W-1:0]   region_start,
    output logic [ADDR_W-1:0]   region_end
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = AW + 1;

    // one memory of packed start, end, offset words
    localparam int MW = 3 * ADDR_W;

    logic [MW-1:0]     mem [ENTRIES];
    logic [MW-1:0]     rd_reg;
    logic [ADDR_W-1:0] a_start_reg, a_end_reg, a_off_reg, q_reg;
    logic [CW-1:0]     count_reg;
    logic              ready_reg;
    logic [CW-1:0]     i_reg, j_reg, lo_reg, hi_reg;
    logic [MW-1:0]     key_reg;
    logic              strobe_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] o_off_reg, o_start_reg, o_end_reg;

    logic [CW-1:0]     mid;
    logic              we;
    logic [AW-1:0]     wa, ra;
    logic [MW-1:0]     wd;
    logic              re;
    logic [ADDR_W-1:0] rd_start, rd_end, rd_off;
    logic              hit;
    logic [CW:0]       lohi;

    assign rd_start = rd_reg[MW-1 -: ADDR_W];
    assign rd_end   = rd_reg[2*ADDR_W-1 -: ADDR_W];
    assign rd_off   = rd_reg[ADDR_W-1:0];

    assign lohi = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid  = lohi[CW:1];
    assign hit  = (rd_start <= q_reg) && (q_reg < rd_end);

    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (ctl.do_insert)
        begin
            we = 1'b1;
            wa = count_reg[AW-1:0];
            wd = {a_start_reg, a_end_reg, a_off_reg};
        end
        else if (ctl.sort_shift)
        begin
            we = 1'b1;
            wa = j_reg[AW-1:0];
            wd = rd_reg;
        end
        else if (ctl.sort_put)
        begin
            we = 1'b1;
            wa = j_reg[AW-1:0];
            wd = key_reg;
        end
    end

    always_comb
    begin
        re = 1'b0;
        ra = '0;
        if (ctl.sort_load_key)
        begin
            re = 1'b1;
            ra = i_reg[AW-1:0];
        end
        else if (ctl.sort_rd)
        begin
            re = 1'b1;
            ra = AW'(j_reg - CW'(1));
        end
        else if (ctl.lk_rd)
        begin
            re = 1'b1;
            ra = mid[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    // key lands in rd_reg in the cycle after load; captured on first compare
    logic key_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ready_reg <= 1'b0;
            strobe_reg <= 1'b0;
            key_pending_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit;
            key_pending_reg <= ctl.sort_load_key;
            if (ctl.do_clear)
            begin
                count_reg <= '0;
                ready_reg <= 1'b0;
            end
            if (ctl.do_insert)
            begin
                count_reg <= count_reg + CW'(1);
                ready_reg <= 1'b0;
            end
            if (ctl.set_ready)
            begin
                ready_reg <= 1'b1;
            end
        end
    end

    logic [MW-1:0] key_now;
    assign key_now = key_pending_reg ? rd_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            a_start_reg <= start_addr;
            a_end_reg   <= end_addr;
            a_off_reg   <= file_offset;
            q_reg       <= query_addr;
        end
        if (key_pending_reg)
        begin
            key_reg <= rd_reg;
        end
        if (ctl.sort_init)
        begin
            i_reg <= CW'(1);
        end
        if (ctl.sort_load_key)
        begin
            j_reg <= i_reg;
        end
        if (ctl.sort_shift)
        begin
            j_reg <= j_reg - CW'(1);
        end
        if (ctl.sort_next)
        begin
            i_reg <= i_reg + CW'(1);
        end
        if (ctl.lk_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        if (ctl.lk_step && !hit)
        begin
            if (q_reg < rd_start)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + CW'(1);
            end
        end
        if (ctl.emit)
        begin
            status_reg  <= ctl.emit_status;
            idx_reg     <= '0;
            o_off_reg   <= '0;
            o_start_reg <= '0;
            o_end_reg   <= '0;
            if (ctl.emit_data && !ready_reg)
            begin
                idx_reg     <= INDEX_W'(count_reg - CW'(1));
                o_off_reg   <= a_off_reg;
                o_start_reg <= a_start_reg;
                o_end_reg   <= a_end_reg;
            end
            else if (ctl.emit_data)
            begin
                idx_reg     <= INDEX_W'(mid);
                o_off_reg   <= rd_off;
                o_start_reg <= rd_start;
                o_end_reg   <= rd_end;
            end
        end
    end

    assign st.full            = (count_reg >= CW'(ENTRIES));
    assign st.ready           = ready_reg;
    assign st.sort_more       = (i_reg < count_reg);
    assign st.sort_can_move   = (j_reg != '0);
    assign st.sort_need_shift = (rd_start > key_now[MW-1 -: ADDR_W]);
    assign st.lk_more         = (lo_reg < hi_reg);
    assign st.lk_hit          = hit;

    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign region_index  = idx_reg;
    assign region_offset = o_off_reg;
    assign region_start  = o_start_reg;
    assign region_end    = o_end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_insert |=> !ready_reg)
        else $error("table ready after insert");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.lk_init |-> ready_reg)
        else $error("search started on unsorted table");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// testbench for sorted_range_table_lookup_top: directed and random commands with a built-in
// region table model, results checked field by field; depends on srtl_pkg and the rtl
module tb;
    import srtl_pkg::*;

    typedef struct {
        logic [1:0]  fn;
        logic [63:0] sa;
        logic [63:0] ea;
        logic [63:0] fo;
        logic        sp;
        logic [63:0] qa;
    } cmd_t;

    typedef struct {
        logic [2:0]  st;
        logic [5:0]  idx;
        logic [63:0] off;
        logic [63:0] rs;
        logic [63:0] re;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [63:0] start_addr;
    logic [63:0] end_addr;
    logic [63:0] file_offset;
    logic        is_special;
    logic [63:0] query_addr;
    logic        strobe;
    logic [2:0]  status;
    logic [5:0]  region_index;
    logic [63:0] region_offset;
    logic [63:0] region_start;
    logic [63:0] region_end;

    cmd_t   cmd_queue[$];
    reply_t expected_replies[$];
    int     errors = 0;
    int     gap = 0;
    bit     hold_for_drain = 0;
    bit     stim_done = 0;

    logic [63:0] tbl_start[64];
    logic [63:0] tbl_end[64];
    logic [63:0] tbl_off[64];
    int          tbl_count = 0;
    bit          tbl_ready = 0;
    logic [63:0] known_start[$];

    sorted_range_table_lookup_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .start_addr(start_addr), .end_addr(end_addr), .file_offset(file_offset),
        .is_special(is_special), .query_addr(query_addr), .strobe(strobe),
        .status(status), .region_index(region_index), .region_offset(region_offset),
        .region_start(region_start), .region_end(region_end)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic reply_t table_apply(cmd_t c);
        reply_t r;
        int lo, hi, mid, i, j;
        logic [63:0] s, e, o;
        r = '{ST_OK, 6'd0, 64'd0, 64'd0, 64'd0};
        case (c.fn)
            FUNC_CLEAR:
            begin
                tbl_count = 0;
                tbl_ready = 0;
            end
            FUNC_INSERT:
            begin
                if (c.sp)
                    r.st = ST_SKIPPED;
                else if (tbl_count >= 64)
                    r.st = ST_FULL;
                else
                begin
                    tbl_start[tbl_count] = c.sa;
                    tbl_end[tbl_count] = c.ea;
                    tbl_off[tbl_count] = c.fo;
                    r = '{ST_OK, tbl_count[5:0], c.fo, c.sa, c.ea};
                    tbl_count++;
                    tbl_ready = 0;
                end
            end
            FUNC_FINISH:
            begin
                for (i = 1; i < tbl_count; i++)
                begin
                    s = tbl_start[i];
                    e = tbl_end[i];
                    o = tbl_off[i];
                    j = i;
                    while (j > 0 && tbl_start[j-1] > s)
                    begin
                        tbl_start[j] = tbl_start[j-1];
                        tbl_end[j] = tbl_end[j-1];
                        tbl_off[j] = tbl_off[j-1];
                        j--;
                    end
                    tbl_start[j] = s;
                    tbl_end[j] = e;
                    tbl_off[j] = o;
                end
                tbl_ready = 1;
            end
            default:
            begin
                if (!tbl_ready)
                    r.st = ST_NOTREADY;
                else
                begin
                    r.st = ST_NOTFOUND;
                    lo = 0;
                    hi = tbl_count;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (tbl_start[mid] <= c.qa && c.qa < tbl_end[mid])
                        begin
                            r = '{ST_OK, mid[5:0], tbl_off[mid], tbl_start[mid],
                                  tbl_end[mid]};
                            break;
                        end
                        if (c.qa < tbl_start[mid])
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random value from 0 up to lim inclusive
    function automatic logic [63:0] rand_upto(logic [63:0] lim);
        return rand64() % (lim + 64'd1);
    endfunction

    task automatic add_cmd(logic [1:0] fn, logic [63:0] sa, logic [63:0] ea,
                           logic [63:0] fo, logic sp, logic [63:0] qa);
        cmd_t c;
        c = '{fn, sa, ea, fo, sp, qa};
        cmd_queue.push_back(c);
        if (fn == FUNC_INSERT && !sp)
            known_start.push_back(sa);
    endtask

    // non-overlapping regions in a shuffled order, then finish and lookups
    task automatic add_table_phase(int n, int lookups);
        logic [63:0] base, step, q;
        logic [63:0] sa[$];
        int i, k;
        base = (($urandom_range(0, 3) == 0) ? rand64() >> 1 : 64'($urandom_range(0, 500)));
        step = 64'($urandom_range(2, 40));
        if ($urandom_range(0, 4) == 0)
            step = 64'h0100_0000_0000_0000 >> $urandom_range(0, 6);
        known_start.delete();
        add_cmd(FUNC_CLEAR, rand64(), rand64(), rand64(), 1'($urandom), rand64());
        for (i = 0; i < n; i++)
            sa.push_back(base + step * i);
        sa.shuffle();
        for (i = 0; i < sa.size(); i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_cmd(FUNC_INSERT, rand64(), rand64(), rand64(), 1'b1, rand64());
            add_cmd(FUNC_INSERT, sa[i], sa[i] + rand_upto(step),
                    rand64(), 1'b0, rand64());
        end
        if ($urandom_range(0, 5) == 0)
            add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, rand64());
        add_cmd(FUNC_FINISH, rand64(), rand64(), rand64(), 1'($urandom), rand64());
        for (i = 0; i < lookups; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 7 && known_start.size() > 0)
                q = known_start[$urandom_range(0, known_start.size() - 1)]
                    + rand_upto(step);
            else if (k < 8)
                q = rand64();
            else
                q = base - 64'($urandom_range(0, 3));
            add_cmd(FUNC_LOOKUP, rand64(), rand64(), rand64(), 1'($urandom), q);
        end
    endtask

    initial
    begin
        int i, n;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_CLEAR;
        start_addr = '0;
        end_addr = '0;
        file_offset = '0;
        is_special = 1'b0;
        query_addr = '0;
        // directed: not ready, skipped, extremes, empty table
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd5);
        add_cmd(FUNC_INSERT, '1, '1, '1, 1'b1, '1);
        add_cmd(FUNC_INSERT, 64'd0, '1, '1, 1'b0, 64'd0);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd5);
        add_cmd(FUNC_FINISH, 0, 0, 0, 0, 0);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd0);
        add_cmd(FUNC_LOOKUP, '1, '1, '1, 1'b1, '1);
        add_cmd(FUNC_INSERT, '1, 64'd0, 64'd0, 1'b0, 0);
        add_cmd(FUNC_INSERT, 64'd9, 64'd9, 64'd3, 1'b0, 0);
        add_cmd(FUNC_FINISH, '1, '1, '1, 1'b1, '1);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd9);
        add_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
        add_cmd(FUNC_FINISH, 0, 0, 0, 0, 0);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd1);
        // equal starts keep insertion order
        add_cmd(FUNC_INSERT, 64'd20, 64'd30, 64'd1, 1'b0, 0);
        add_cmd(FUNC_INSERT, 64'd10, 64'd20, 64'd2, 1'b0, 0);
        add_cmd(FUNC_INSERT, 64'd20, 64'd25, 64'd3, 1'b0, 0);
        add_cmd(FUNC_FINISH, 0, 0, 0, 0, 0);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd19);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd22);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, 64'd30);
        add_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
        // full table: 64 regions plus overflow inserts
        add_table_phase(64, 0);
        add_cmd(FUNC_INSERT, rand64(), rand64(), rand64(), 1'b0, 0);
        add_cmd(FUNC_INSERT, rand64(), rand64(), rand64(), 1'b0, 0);
        add_cmd(FUNC_LOOKUP, 0, 0, 0, 0, rand64());
        for (i = 0; i < 40; i++)
            add_cmd(FUNC_LOOKUP, rand64(), rand64(), rand64(), 1'($urandom),
                    known_start[$urandom_range(0, 63)]);
        n = 0;
        while (n < 14)
        begin
            add_table_phase($urandom_range(1, 12), $urandom_range(10, 30));
            n++;
        end
        for (i = 0; i < 40; i++)
            add_cmd(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(),
                    1'($urandom), rand64());
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_replies.push_back(table_apply('{func, start_addr, end_addr,
                                           file_offset, is_special, query_addr}));
                gap = ($urandom_range(0, 9) < 6) ? 0 :
                      (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3));
                if (cmd_queue.size() == 130)
                    hold_for_drain = 1;
            end
            if (!start || !busy)
            begin
                if (hold_for_drain && (expected_replies.size() > 0 || start))
                    start <= 1'b0;
                else if (gap > 0 && !(start && busy))
                begin
                    gap <= gap - 1;
                    start <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    hold_for_drain = 0;
                    c = cmd_queue.pop_front();
                    start <= 1'b1;
                    func <= c.fn;
                    start_addr <= c.sa;
                    end_addr <= c.ea;
                    file_offset <= c.fo;
                    is_special <= c.sp;
                    query_addr <= c.qa;
                end
                else
                begin
                    start <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t x;
        if (rst_n && strobe)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result status %0d", $time, status);
                errors++;
            end
            else
            begin
                x = expected_replies.pop_front();
                if (status !== x.st || region_index !== x.idx || region_offset !== x.off
                    || region_start !== x.rs || region_end !== x.re)
                begin
                    $display("%0t: mismatch expected st=%0d idx=%0d off=%h start=%h end=%h",
                             $time, x.st, x.idx, x.off, x.rs, x.re);
                    $display("%0t:            actual st=%0d idx=%0d off=%h start=%h end=%h",
                             $time, status, region_index, region_offset,
                             region_start, region_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && expected_replies.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb failed");
        $finish;
    end
endmodule

/* sorted_range_table_lookup_top.f */
src/srtl_pkg.sv
src/srtl_ctrl.sv
src/srtl_dp.sv
src/sorted_range_table_lookup_top.sv
tb/sv/tb.sv
